FILE: rtl/protobuf_wire_field_parser_top_assert.svh
// Assertion macros for the protobuf wire field parser.
// Depends on signals named clk and rst_n at the point of use.
`ifndef PROTOBUF_WIRE_FIELD_PARSER_TOP_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PBWF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PBWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pbwf_pkg.sv
// Shared types, codes and defaults for the protobuf wire field parser.
// No dependencies.
package pbwf_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 10;
    localparam int LENGTH_BITS_DEF      = 32;

    // Decoder phases
    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_SCALAR  = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_FIELD_ZERO = 3'd1;
    localparam logic [2:0] ERR_VARINT_LEN = 3'd2;
    localparam logic [2:0] ERR_WIRE_TYPE  = 3'd3;
    localparam logic [2:0] ERR_LEN_WIDE   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd5;

    // Wire types
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LEN     = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    localparam logic [3:0] FIXED64_BYTES = 4'd8;
    localparam logic [3:0] FIXED32_BYTES = 4'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } pbwf_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] field_value;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic        message_end;
    } pbwf_out_t;

    // Decoder state apart from the payload counter, whose width is a parameter
    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] accumulator;
        logic [3:0]  byte_count;
        logic [31:0] current_field;
        logic [2:0]  current_wire;
    } pbwf_state_t;

    localparam pbwf_state_t STATE_RESET = '0;

endpackage

FILE: rtl/pbwf_step.sv
// Next-state and result logic for one byte of the protobuf wire field parser.
// Depends on pbwf_pkg.
module pbwf_step #(
    parameter int MAX_VARINT_BYTES = pbwf_pkg::MAX_VARINT_BYTES_DEF,
    parameter int LENGTH_BITS      = pbwf_pkg::LENGTH_BITS_DEF
) (
    input  pbwf_pkg::pbwf_state_t  state_cur,
    input  logic [LENGTH_BITS-1:0] left_cur,
    input  pbwf_pkg::pbwf_in_t     item,
    output pbwf_pkg::pbwf_state_t  state_nxt,
    output logic [LENGTH_BITS-1:0] left_nxt,
    output logic                   res_valid,
    output pbwf_pkg::pbwf_out_t    res
);
    import pbwf_pkg::*;

    localparam logic [3:0] MaxBytes = 4'(MAX_VARINT_BYTES);

    logic [3:0]             cnt_inc;
    logic [6:0]             vshift;
    logic [63:0]            vacc;
    logic [63:0]            facc;
    logic [3:0]             need;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   last;
    logic                   cont;
    logic                   do_fail;
    logic [2:0]             fail_code;

    assign last     = item.last_byte;
    assign cont     = item.in_byte[7];
    assign cnt_inc  = state_cur.byte_count + 4'd1;
    // 7 * byte_count; positions at or past bit 64 shift out
    assign vshift   = {state_cur.byte_count, 3'b000} - {3'b000, state_cur.byte_count};
    assign vacc     = state_cur.accumulator | ({57'b0, item.in_byte[6:0]} << vshift);
    assign facc     = state_cur.accumulator
                    | ({56'b0, item.in_byte} << {state_cur.byte_count[2:0], 3'b000});
    assign need     = (state_cur.current_wire == WIRE_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
    assign left_dec = left_cur - LENGTH_BITS'(1);

    always_comb
    begin
        state_nxt = state_cur;
        left_nxt  = left_cur;
        res_valid = 1'b0;
        res       = '0;
        do_fail   = 1'b0;
        fail_code = ERR_NONE;

        unique case (state_cur.phase)
            PH_ERROR:
            begin
                if (last)
                begin
                    state_nxt       = STATE_RESET;
                    left_nxt        = '0;
                    res_valid       = 1'b1;
                    res.kind        = KIND_END;
                    res.message_end = 1'b1;
                end
            end
            PH_VARINT, PH_LENGTH:
            begin
                state_nxt.accumulator = vacc;
                state_nxt.byte_count  = cnt_inc;
                if (cont)
                begin
                    if (cnt_inc >= MaxBytes)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_VARINT_LEN;
                    end
                    else if (last)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                end
                else if (state_cur.phase == PH_VARINT)
                begin
                    state_nxt        = STATE_RESET;
                    left_nxt         = '0;
                    res_valid        = 1'b1;
                    res.kind         = KIND_SCALAR;
                    res.field_number = state_cur.current_field;
                    res.wire_kind    = state_cur.current_wire;
                    res.field_value  = vacc;
                    res.message_end  = last;
                end
                else if ((vacc >> LENGTH_BITS) != 64'd0)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LEN_WIDE;
                end
                else if (vacc == 64'd0)
                begin
                    state_nxt        = STATE_RESET;
                    left_nxt         = '0;
                    res_valid        = 1'b1;
                    res.kind         = KIND_HEADER;
                    res.field_number = state_cur.current_field;
                    res.wire_kind    = state_cur.current_wire;
                    res.message_end  = last;
                end
                else if (last)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
                else
                begin
                    state_nxt.accumulator = '0;
                    state_nxt.byte_count  = '0;
                    state_nxt.phase       = PH_PAYLOAD;
                    left_nxt              = vacc[LENGTH_BITS-1:0];
                    res_valid             = 1'b1;
                    res.kind              = KIND_HEADER;
                    res.field_number      = state_cur.current_field;
                    res.wire_kind         = state_cur.current_wire;
                    res.field_value       = vacc;
                end
            end
            PH_FIXED:
            begin
                state_nxt.accumulator = facc;
                state_nxt.byte_count  = cnt_inc;
                if (cnt_inc < need)
                begin
                    if (last)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                end
                else
                begin
                    state_nxt        = STATE_RESET;
                    left_nxt         = '0;
                    res_valid        = 1'b1;
                    res.kind         = KIND_SCALAR;
                    res.field_number = state_cur.current_field;
                    res.wire_kind    = state_cur.current_wire;
                    res.field_value  = facc;
                    res.message_end  = last;
                end
            end
            PH_PAYLOAD:
            begin
                left_nxt = left_dec;
                if (left_dec == '0)
                begin
                    state_nxt        = STATE_RESET;
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.field_number = state_cur.current_field;
                    res.wire_kind    = state_cur.current_wire;
                    res.payload_byte = item.in_byte;
                    res.message_end  = last;
                end
                else if (last)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.field_number = state_cur.current_field;
                    res.wire_kind    = state_cur.current_wire;
                    res.payload_byte = item.in_byte;
                end
            end
            default:
            begin
                // expecting a key; unreachable phase codes behave the same
                state_nxt.phase       = PH_KEY;
                state_nxt.accumulator = vacc;
                state_nxt.byte_count  = cnt_inc;
                if (cont)
                begin
                    if (cnt_inc >= MaxBytes)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_VARINT_LEN;
                    end
                    else if (last)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                end
                else
                begin
                    state_nxt.accumulator   = '0;
                    state_nxt.byte_count    = '0;
                    state_nxt.current_field = vacc[34:3];
                    state_nxt.current_wire  = vacc[2:0];
                    if (vacc[63:3] == 61'd0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_FIELD_ZERO;
                    end
                    else if (vacc[2:0] != WIRE_VARINT && vacc[2:0] != WIRE_FIXED64
                             && vacc[2:0] != WIRE_LEN && vacc[2:0] != WIRE_FIXED32)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_WIRE_TYPE;
                    end
                    else if (last)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else if (vacc[2:0] == WIRE_VARINT)
                        state_nxt.phase = PH_VARINT;
                    else if (vacc[2:0] == WIRE_LEN)
                        state_nxt.phase = PH_LENGTH;
                    else
                        state_nxt.phase = PH_FIXED;
                end
            end
        endcase

        // Report the error with whatever key is known, then drop to reset or wait state
        if (do_fail)
        begin
            res_valid        = 1'b1;
            res              = '0;
            res.kind         = KIND_ERROR;
            res.field_number = state_nxt.current_field;
            res.wire_kind    = state_nxt.current_wire;
            res.error_code   = fail_code;
            res.message_end  = last;
            left_nxt         = '0;
            if (last)
                state_nxt = STATE_RESET;
            else
            begin
                state_nxt.phase       = PH_ERROR;
                state_nxt.accumulator = '0;
                state_nxt.byte_count  = '0;
            end
        end
    end

endmodule

FILE: rtl/protobuf_wire_field_parser_top.sv
// Top level of the protobuf wire field parser: byte register, step logic, result register.
// Depends on pbwf_pkg, pbwf_step and protobuf_wire_field_parser_top_assert.svh.
//
// Usage:
//   Byte channel (byte_valid, byte_stall, byte_data) carries one buffer byte per
//   transfer, with last_byte set on the final byte of the buffer.
//   Field channel (field_valid, field_stall, field_data) carries zero or one
//   result per byte: scalar fields, length headers, payload bytes, errors and
//   the end marker that closes a buffer after an error.
//   A transfer happens at a clock edge with valid high and stall low.
// Timing:
//   One byte per cycle sustained while field_stall stays low. A byte lands in
//   the byte register at its transfer edge and its result lands in the result
//   register when the byte leaves the byte register, from where it is offered
//   on the field channel. The decoder state loop (one step of shifts and
//   compares per byte) sets the rate.
// Stalls:
//   While field_stall holds a result, the byte register still takes one more
//   byte; after that byte_stall rises until the result drains.
// Reset:
//   rst_n clears both registers' valid flags and returns the decoder to the
//   expecting-key phase with all counters and accumulators at zero.
`include "protobuf_wire_field_parser_top_assert.svh"

module protobuf_wire_field_parser_top #(
    parameter int MAX_VARINT_BYTES = pbwf_pkg::MAX_VARINT_BYTES_DEF,
    parameter int LENGTH_BITS      = pbwf_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  pbwf_pkg::pbwf_in_t  byte_data,
    output logic                field_valid,
    input  logic                field_stall,
    output pbwf_pkg::pbwf_out_t field_data
);
    import pbwf_pkg::*;

    // Byte register
    logic                   item_valid_reg;
    pbwf_in_t               item_reg;

    // Decoder state
    pbwf_state_t            state_reg;
    pbwf_state_t            state_next;
    logic [LENGTH_BITS-1:0] left_reg;
    logic [LENGTH_BITS-1:0] left_next;

    // Result register
    logic                   res_valid_reg;
    pbwf_out_t              res_reg;
    logic                   res_valid_next;
    pbwf_out_t              res_next;

    logic                   advance;
    logic                   take;

    // Retire the held byte once the result register is empty or draining
    assign advance    = item_valid_reg && (!res_valid_reg || !field_stall);
    assign byte_stall = item_valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    assign field_valid = res_valid_reg;
    assign field_data  = res_reg;

    pbwf_step #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_step (
        .state_cur(state_reg),
        .left_cur (left_reg),
        .item     (item_reg),
        .state_nxt(state_next),
        .left_nxt (left_next),
        .res_valid(res_valid_next),
        .res      (res_next)
    );

    // Control: valid flags and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= STATE_RESET;
            left_reg       <= '0;
        end
        else
        begin
            if (take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= res_valid_next;
                state_reg     <= state_next;
                left_reg      <= left_next;
            end
            else if (!field_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload: hold the byte and the result until they move on
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= byte_data;
        if (advance && res_valid_next)
            res_reg <= res_next;
    end

    `PBWF_ASSERT_SAME(a_stall_needs_byte, byte_stall, item_valid_reg,
        "byte_stall without a held byte")
    `PBWF_ASSERT_SAME(a_end_closes, field_valid && field_data.kind == KIND_END,
        field_data.message_end && field_data.error_code == ERR_NONE,
        "end marker without message_end")
    `PBWF_ASSERT_SAME(a_err_code_kind, field_valid,
        (field_data.kind == KIND_ERROR) == (field_data.error_code != ERR_NONE),
        "error code disagrees with kind")
    `PBWF_ASSERT_NEXT(a_end_resets, advance && res_valid_next && res_next.message_end,
        state_reg == STATE_RESET && left_reg == '0,
        "state not cleared after buffer end")
    `PBWF_ASSERT_SAME(a_count_bound,
        state_reg.phase == PH_KEY || state_reg.phase == PH_VARINT || state_reg.phase == PH_LENGTH,
        state_reg.byte_count < 4'(MAX_VARINT_BYTES), "varint byte count past limit")

endmodule
